// File: rtl/core/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Types, constants and the control store of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int BLOCKS = 128;
    localparam int FILES  = 16;
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int ENT_W  = $clog2(FILES);
    localparam int CNT_W  = $clog2(FILES + 1);
    localparam int CFG_W  = 8;
    localparam int STEP_W = 5;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCK_COUNT = 1'b0;

    typedef logic [STEP_W-1:0] t_step;

    // control store addresses
    localparam t_step S_CLEAR  = 5'd0;
    localparam t_step S_IDLE   = 5'd1;
    localparam t_step S_DISP   = 5'd2;
    localparam t_step S_RANGE  = 5'd3;
    localparam t_step S_READ   = 5'd4;
    localparam t_step S_TEST   = 5'd5;
    localparam t_step S_NEXT   = 5'd6;
    localparam t_step S_ROOM   = 5'd7;
    localparam t_step S_MARK   = 5'd8;
    localparam t_step S_RECORD = 5'd9;
    localparam t_step S_LOOKUP = 5'd10;
    localparam t_step S_UNMARK = 5'd11;
    localparam t_step S_KILL   = 5'd12;
    localparam t_step S_E_BAD  = 5'd13;
    localparam t_step S_E_BUSY = 5'd14;
    localparam t_step S_E_FULL = 5'd15;
    localparam t_step S_E_NF   = 5'd16;
    localparam t_step S_DONE   = 5'd17;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_FREE,
        C_BAD_RANGE,
        C_MAP_SET,
        C_NOT_LAST,
        C_FULL,
        C_NOT_FOUND,
        C_NOT_END
    } t_cond;

    typedef enum logic [1:0] {
        AD_HOLD,
        AD_FIRST,
        AD_ENTRY,
        AD_INC
    } t_addr_op;

    typedef enum logic [1:0] {
        M_NONE,
        M_SET,
        M_CLR
    } t_mem_op;

    typedef enum logic [2:0] {
        A_NONE,
        A_RECORD,
        A_KILL,
        A_STATUS,
        A_BUSY,
        A_STROBE
    } t_act;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_RANGE = 3'd1,
        ST_BUSY      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic {
        F_ALLOC = 1'b0,
        F_FREE  = 1'b1
    } t_func;

    typedef struct packed {
        t_cond    cond;
        t_step    target;
        t_addr_op addr_op;
        t_mem_op  mem_op;
        t_act     act;
        t_status  status;
        logic     idle;
    } t_ctl;

    function automatic t_ctl mk(input t_cond cond, input t_step target,
                                input t_addr_op addr_op, input t_mem_op mem_op,
                                input t_act act, input t_status status,
                                input logic idle);
        t_ctl c;
        c.cond    = cond;
        c.target  = target;
        c.addr_op = addr_op;
        c.mem_op  = mem_op;
        c.act     = act;
        c.status  = status;
        c.idle    = idle;
        return c;
    endfunction

    // control store: jump to target when cond holds, else next step
    function automatic t_ctl ucode(input t_step pc);
        t_ctl c;
        c = mk(C_ALWAYS, S_IDLE, AD_HOLD, M_NONE, A_NONE, ST_OK, 1'b0);
        unique case (pc)
            S_CLEAR:  c = mk(C_NOT_END, S_CLEAR, AD_INC, M_CLR, A_NONE, ST_OK, 1'b0);
            S_IDLE:   c = mk(C_NOT_START, S_IDLE, AD_HOLD, M_NONE, A_NONE, ST_OK, 1'b1);
            S_DISP:   c = mk(C_FREE, S_LOOKUP, AD_FIRST, M_NONE, A_NONE, ST_OK, 1'b0);
            S_RANGE:  c = mk(C_BAD_RANGE, S_E_BAD, AD_HOLD, M_NONE, A_NONE, ST_OK, 1'b0);
            S_READ:   c = mk(C_NEVER, S_IDLE, AD_HOLD, M_NONE, A_NONE, ST_OK, 1'b0);
            S_TEST:   c = mk(C_MAP_SET, S_E_BUSY, AD_HOLD, M_NONE, A_NONE, ST_OK, 1'b0);
            S_NEXT:   c = mk(C_NOT_LAST, S_READ, AD_INC, M_NONE, A_NONE, ST_OK, 1'b0);
            S_ROOM:   c = mk(C_FULL, S_E_FULL, AD_FIRST, M_NONE, A_NONE, ST_OK, 1'b0);
            S_MARK:   c = mk(C_NOT_LAST, S_MARK, AD_INC, M_SET, A_NONE, ST_OK, 1'b0);
            S_RECORD: c = mk(C_ALWAYS, S_DONE, AD_HOLD, M_NONE, A_RECORD, ST_OK, 1'b0);
            S_LOOKUP: c = mk(C_NOT_FOUND, S_E_NF, AD_ENTRY, M_NONE, A_NONE, ST_OK, 1'b0);
            S_UNMARK: c = mk(C_NOT_LAST, S_UNMARK, AD_INC, M_CLR, A_NONE, ST_OK, 1'b0);
            S_KILL:   c = mk(C_ALWAYS, S_DONE, AD_HOLD, M_NONE, A_KILL, ST_OK, 1'b0);
            S_E_BAD:  c = mk(C_ALWAYS, S_DONE, AD_HOLD, M_NONE, A_STATUS,
                             ST_BAD_RANGE, 1'b0);
            S_E_BUSY: c = mk(C_ALWAYS, S_DONE, AD_HOLD, M_NONE, A_BUSY, ST_BUSY, 1'b0);
            S_E_FULL: c = mk(C_ALWAYS, S_DONE, AD_HOLD, M_NONE, A_STATUS, ST_FULL, 1'b0);
            S_E_NF:   c = mk(C_ALWAYS, S_DONE, AD_HOLD, M_NONE, A_STATUS,
                             ST_NOT_FOUND, 1'b0);
            S_DONE:   c = mk(C_ALWAYS, S_IDLE, AD_HOLD, M_NONE, A_STROBE, ST_OK, 1'b0);
            default:  c = mk(C_ALWAYS, S_IDLE, AD_HOLD, M_NONE, A_NONE, ST_OK, 1'b0);
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// Block-in-use bitmap and file table run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. func selects an
// allocate of first_block..last_block or a free of file_id. Exactly one
// result follows, shown for one cycle with o_done high; the receiver cannot
// stall it. The block_count register is to be written over the APB port
// while busy is low; the block does not enforce this. pready is always high.
// An allocate first checks each block of the range through the read, test
// and next steps around the registered bitmap read, and then marks each
// block; a free unmarks each block of the entry. o_done is high in the
// cycle before busy falls.
// One request at a time: busy stays high from transfer to o_done.
// After reset a clearing pass walks the bitmap, one block per cycle, with
// busy high; register writes are taken during it. Reset also empties the
// file table.
// ----------------------------------------------------------------------------
module contiguous_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [cba_pkg::BLK_W-1:0]     i_first_block,
    input  logic [cba_pkg::BLK_W-1:0]     i_last_block,
    input  logic [cba_pkg::CNT_W-1:0]     i_file_id,
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [cba_pkg::CNT_W-1:0]     o_new_file_id,
    output logic [cba_pkg::BLK_W-1:0]     o_busy_block,
    output logic [cba_pkg::CNT_W-1:0]     o_files_recorded,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    cba_pkg::t_ctl                    w_ctl;
    cba_pkg::t_step                   r_pc;
    cba_pkg::t_step                   n_pc;
    logic                             w_take;
    logic                             w_accept;

    logic [cba_pkg::CFG_W-1:0]        r_block_count;

    logic                             r_func;
    logic [cba_pkg::BLK_W-1:0]        r_first;
    logic [cba_pkg::BLK_W-1:0]        r_last;
    logic [cba_pkg::CNT_W-1:0]        r_id;
    logic [2:0]                       r_status;
    logic [cba_pkg::CNT_W-1:0]        r_new_id;
    logic [cba_pkg::BLK_W-1:0]        r_busy;
    logic [cba_pkg::CNT_W-1:0]        r_count;

    logic [cba_pkg::BLK_W-1:0]        r_addr;
    logic                             r_map [cba_pkg::BLOCKS];
    logic                             r_rd;

    logic [cba_pkg::BLK_W-1:0]        r_ent_first [cba_pkg::FILES];
    logic [cba_pkg::BLK_W-1:0]        r_ent_last  [cba_pkg::FILES];
    logic [cba_pkg::FILES-1:0]        r_live;

    logic [cba_pkg::CNT_W-1:0]        w_id_dec;
    logic [cba_pkg::ENT_W-1:0]        w_idx;
    logic [cba_pkg::ENT_W-1:0]        w_wr_idx;

    assign w_ctl    = cba_pkg::ucode(r_pc);
    assign busy     = !w_ctl.idle;
    assign w_accept = start && w_ctl.idle;
    assign w_id_dec = r_id - cba_pkg::CNT_W'(1);
    assign w_idx    = w_id_dec[cba_pkg::ENT_W-1:0];
    assign w_wr_idx = r_count[cba_pkg::ENT_W-1:0];

    // jump condition
    always_comb begin
        unique case (w_ctl.cond)
            cba_pkg::C_NEVER:     w_take = 1'b0;
            cba_pkg::C_ALWAYS:    w_take = 1'b1;
            cba_pkg::C_NOT_START: w_take = !start;
            cba_pkg::C_FREE:      w_take = (r_func == cba_pkg::F_FREE);
            cba_pkg::C_BAD_RANGE: w_take = (r_first > r_last) ||
                                           ({1'b0, r_last} >= r_block_count);
            cba_pkg::C_MAP_SET:   w_take = r_rd;
            cba_pkg::C_NOT_LAST:  w_take = (r_addr != r_last);
            cba_pkg::C_FULL:      w_take = (r_count >= cba_pkg::CNT_W'(cba_pkg::FILES));
            cba_pkg::C_NOT_FOUND: w_take = (r_id == '0) || (r_id > r_count) ||
                                           !r_live[w_idx];
            cba_pkg::C_NOT_END:   w_take = (r_addr != cba_pkg::BLK_W'(cba_pkg::BLOCKS - 1));
            default:              w_take = 1'b0;
        endcase
        n_pc = w_take ? w_ctl.target : r_pc + cba_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cba_pkg::S_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= cba_pkg::CFG_W'(128);
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == cba_pkg::REG_BLOCK_COUNT)) begin
            r_block_count <= pwdata[cba_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cba_pkg::REG_BLOCK_COUNT)
                    ? {{(32 - cba_pkg::CFG_W){1'b0}}, r_block_count} : 32'd0;

    // block pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            unique case (w_ctl.addr_op)
                cba_pkg::AD_HOLD:  r_addr <= r_addr;
                cba_pkg::AD_FIRST: r_addr <= r_first;
                cba_pkg::AD_ENTRY: r_addr <= r_ent_first[w_idx];
                cba_pkg::AD_INC:   r_addr <= r_addr + cba_pkg::BLK_W'(1);
                default:           r_addr <= r_addr;
            endcase
        end
    end

    // bitmap
    always_ff @(posedge i_clk) begin
        if (w_ctl.mem_op == cba_pkg::M_SET) begin
            r_map[r_addr] <= 1'b1;
        end else if (w_ctl.mem_op == cba_pkg::M_CLR) begin
            r_map[r_addr] <= 1'b0;
        end
        r_rd <= r_map[r_addr];
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_first  <= i_first_block;
            r_last   <= i_last_block;
            r_id     <= i_file_id;
            r_status <= cba_pkg::ST_OK;
            r_new_id <= '0;
            r_busy   <= '0;
        end else begin
            if (w_ctl.addr_op == cba_pkg::AD_ENTRY) begin
                r_last <= r_ent_last[w_idx];
            end
            if (w_ctl.act == cba_pkg::A_STATUS || w_ctl.act == cba_pkg::A_BUSY) begin
                r_status <= w_ctl.status;
            end
            if (w_ctl.act == cba_pkg::A_BUSY) begin
                r_busy <= r_addr;
            end
            if (w_ctl.act == cba_pkg::A_RECORD) begin
                r_new_id <= r_count + cba_pkg::CNT_W'(1);
            end
        end
    end

    // file table
    always_ff @(posedge i_clk) begin
        if (w_ctl.act == cba_pkg::A_RECORD) begin
            r_ent_first[w_wr_idx] <= r_first;
            r_ent_last[w_wr_idx]  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_count <= '0;
        end else if (w_ctl.act == cba_pkg::A_RECORD) begin
            r_live[w_wr_idx] <= 1'b1;
            r_count          <= r_count + cba_pkg::CNT_W'(1);
        end else if (w_ctl.act == cba_pkg::A_KILL) begin
            r_live[w_idx] <= 1'b0;
        end
    end

    assign o_done           = (w_ctl.act == cba_pkg::A_STROBE);
    assign o_status         = r_status;
    assign o_new_file_id    = r_new_id;
    assign o_busy_block     = r_busy;
    assign o_files_recorded = r_count;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the contiguous block allocator. A queue of
// requests and block_count writes feeds a clocked driver; a shadow bitmap
// and file table predict each result, and a clocked monitor compares every
// o_done transfer field by field. Directed corner cases come first, then
// random phases at several store sizes, with random start gaps.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] BLOCK_COUNT_ADDR = {cba_pkg::REG_BLOCK_COUNT, 2'b00};
    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         MAX_PRINTS       = 100;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_SETTLE,
        OP_CONFIG
    } t_op_kind;

    typedef enum logic [1:0] {
        D_IDLE,
        D_ITEM,
        D_SETUP,
        D_ACCESS
    } t_drv_state;

    typedef struct {
        t_op_kind                  kind;
        cba_pkg::t_func            func;
        logic [cba_pkg::BLK_W-1:0] first;
        logic [cba_pkg::BLK_W-1:0] last;
        logic [cba_pkg::CNT_W-1:0] fid;
        logic [cba_pkg::CFG_W-1:0] cfg;
        bit                        gaps;
    } t_stim_op;

    typedef struct {
        cba_pkg::t_status          status;
        logic [cba_pkg::CNT_W-1:0] new_id;
        logic [cba_pkg::BLK_W-1:0] busy_blk;
        logic [cba_pkg::CNT_W-1:0] recorded;
    } t_alloc_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_func = 1'b0;
    logic [cba_pkg::BLK_W-1:0]     i_first_block = '0;
    logic [cba_pkg::BLK_W-1:0]     i_last_block = '0;
    logic [cba_pkg::CNT_W-1:0]     i_file_id = '0;
    logic                          o_done;
    logic [2:0]                    o_status;
    logic [cba_pkg::CNT_W-1:0]     o_new_file_id;
    logic [cba_pkg::BLK_W-1:0]     o_busy_block;
    logic [cba_pkg::CNT_W-1:0]     o_files_recorded;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // shadow of the allocator state
    bit                            blk_used [cba_pkg::BLOCKS];
    logic [cba_pkg::BLK_W-1:0]     ent_lo [cba_pkg::FILES];
    logic [cba_pkg::BLK_W-1:0]     ent_hi [cba_pkg::FILES];
    bit                            ent_live [cba_pkg::FILES];
    int                            ent_used = 0;
    logic [cba_pkg::CFG_W-1:0]     cfg_blocks = 8'd128;

    t_stim_op                      request_q[$];
    t_alloc_result                 expected_q[$];
    t_drv_state                    drv_state = D_IDLE;
    bit                            stim_done = 1'b0;
    int                            error_count = 0;
    int                            requests_sent = 0;
    int                            results_checked = 0;
    int                            cfg_writes = 0;
    int                            status_seen [8];
    int                            stall_cycles = 0;

    contiguous_block_allocator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_first_block    (i_first_block),
        .i_last_block     (i_last_block),
        .i_file_id        (i_file_id),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_new_file_id    (o_new_file_id),
        .o_busy_block     (o_busy_block),
        .o_files_recorded (o_files_recorded),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_alloc_result predict_request(
        input cba_pkg::t_func            fn,
        input logic [cba_pkg::BLK_W-1:0] lo,
        input logic [cba_pkg::BLK_W-1:0] hi,
        input logic [cba_pkg::CNT_W-1:0] fid);
        t_alloc_result r;
        int            span;
        int            b;
        bit            hit;
        r.status   = cba_pkg::ST_OK;
        r.new_id   = '0;
        r.busy_blk = '0;
        span = (int'(cfg_blocks) > cba_pkg::BLOCKS) ? cba_pkg::BLOCKS : int'(cfg_blocks);
        if (fn == cba_pkg::F_ALLOC) begin
            if (lo > hi || int'(hi) >= span) begin
                r.status = cba_pkg::ST_BAD_RANGE;
            end else begin
                hit = 1'b0;
                for (b = int'(lo); b <= int'(hi); b++) begin
                    if (!hit && blk_used[b]) begin
                        hit        = 1'b1;
                        r.busy_blk = cba_pkg::BLK_W'(b);
                    end
                end
                if (hit) begin
                    r.status = cba_pkg::ST_BUSY;
                end else if (ent_used >= cba_pkg::FILES) begin
                    r.status = cba_pkg::ST_FULL;
                end else begin
                    ent_lo[ent_used]   = lo;
                    ent_hi[ent_used]   = hi;
                    ent_live[ent_used] = 1'b1;
                    for (b = int'(lo); b <= int'(hi); b++) blk_used[b] = 1'b1;
                    ent_used++;
                    r.new_id = cba_pkg::CNT_W'(ent_used);
                end
            end
        end else begin
            if (fid == 0 || int'(fid) > ent_used || !ent_live[fid - 1]) begin
                r.status = cba_pkg::ST_NOT_FOUND;
            end else begin
                for (b = int'(ent_lo[fid - 1]); b <= int'(ent_hi[fid - 1]); b++) begin
                    blk_used[b] = 1'b0;
                end
                ent_live[fid - 1] = 1'b0;
            end
        end
        r.recorded = cba_pkg::CNT_W'(ent_used);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic push_request(input cba_pkg::t_func fn, input int lo, input int hi,
                                input int fid, input bit gaps);
        t_stim_op op;
        op.kind  = OP_ITEM;
        op.func  = fn;
        op.first = cba_pkg::BLK_W'(lo);
        op.last  = cba_pkg::BLK_W'(hi);
        op.fid   = cba_pkg::CNT_W'(fid);
        op.cfg   = '0;
        op.gaps  = gaps;
        request_q.push_back(op);
    endtask

    task automatic push_control(input t_op_kind kind, input int value);
        t_stim_op op;
        op.kind  = kind;
        op.func  = cba_pkg::F_ALLOC;
        op.first = '0;
        op.last  = '0;
        op.fid   = '0;
        op.cfg   = cba_pkg::CFG_W'(value);
        op.gaps  = 1'b0;
        request_q.push_back(op);
    endtask

    task automatic add_random_phase(input int blocks, input int count, input int quiet);
        int span;
        int lo;
        int hi;
        int pick;
        int n;
        span = (blocks > cba_pkg::BLOCKS) ? cba_pkg::BLOCKS : blocks;
        push_control(OP_SETTLE, 0);
        push_control(OP_CONFIG, blocks);
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                lo = $urandom_range(span - 1, 0);
                hi = lo + (($urandom_range(99) < 80) ? $urandom_range(7, 0)
                                                      : $urandom_range(127, 0));
                if (hi > span - 1) hi = span - 1;
                push_request(cba_pkg::F_ALLOC, lo, hi, $urandom_range(cba_pkg::FILES, 0),
                             n >= quiet);
            end else if (pick < 80) begin
                push_request(cba_pkg::F_FREE, $urandom_range(127, 0), $urandom_range(127, 0),
                             $urandom_range(cba_pkg::FILES, 1), n >= quiet);
            end else begin
                push_request(cba_pkg::t_func'($urandom_range(1, 0)), $urandom_range(127, 0),
                             $urandom_range(127, 0), $urandom_range(cba_pkg::FILES, 0),
                             n >= quiet);
            end
            if (n == count / 2) push_control(OP_SETTLE, 0);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_stim_op                  op;
        t_alloc_result             res;
        t_drv_state                nxt_state;
        logic                      nxt_start;
        logic                      nxt_psel;
        logic                      nxt_penable;
        logic                      nxt_pwrite;
        logic [31:0]               nxt_pwdata;
        logic                      nxt_func;
        logic [cba_pkg::BLK_W-1:0] nxt_first;
        logic [cba_pkg::BLK_W-1:0] nxt_last;
        logic [cba_pkg::CNT_W-1:0] nxt_fid;
        bit                        free_now;
        if (!i_rst_n) begin
            start     <= 1'b0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state <= D_IDLE;
        end else begin
            nxt_state   = drv_state;
            nxt_start   = start;
            nxt_psel    = psel;
            nxt_penable = penable;
            nxt_pwrite  = pwrite;
            nxt_pwdata  = pwdata;
            nxt_func    = i_func;
            nxt_first   = i_first_block;
            nxt_last    = i_last_block;
            nxt_fid     = i_file_id;
            free_now    = 1'b0;
            case (drv_state)
                D_IDLE: begin
                    free_now = 1'b1;
                end
                D_ITEM: begin
                    if (!busy) begin
                        res = predict_request(cba_pkg::t_func'(i_func), i_first_block,
                                              i_last_block, i_file_id);
                        expected_q.push_back(res);
                        requests_sent++;
                        free_now = 1'b1;
                    end
                end
                D_SETUP: begin
                    nxt_penable = 1'b1;
                    nxt_state   = D_ACCESS;
                end
                D_ACCESS: begin
                    if (pready) begin
                        cfg_blocks = pwdata[cba_pkg::CFG_W-1:0];
                        cfg_writes++;
                        nxt_psel    = 1'b0;
                        nxt_penable = 1'b0;
                        nxt_pwrite  = 1'b0;
                        free_now    = 1'b1;
                    end
                end
                default: free_now = 1'b1;
            endcase
            if (free_now) begin
                nxt_start = 1'b0;
                nxt_state = D_IDLE;
                if (request_q.size() == 0) begin
                    stim_done <= 1'b1;
                end else begin
                    op = request_q[0];
                    case (op.kind)
                        OP_ITEM: begin
                            if (!op.gaps || $urandom_range(99) >= 10) begin
                                void'(request_q.pop_front());
                                nxt_func  = op.func;
                                nxt_first = op.first;
                                nxt_last  = op.last;
                                nxt_fid   = op.fid;
                                nxt_start = 1'b1;
                                nxt_state = D_ITEM;
                            end
                        end
                        OP_SETTLE: begin
                            if (expected_q.size() == 0 && !busy) void'(request_q.pop_front());
                        end
                        OP_CONFIG: begin
                            if (expected_q.size() == 0 && !busy) begin
                                void'(request_q.pop_front());
                                nxt_psel    = 1'b1;
                                nxt_penable = 1'b0;
                                nxt_pwrite  = 1'b1;
                                nxt_pwdata  = {{(32 - cba_pkg::CFG_W){1'b0}}, op.cfg};
                                nxt_state   = D_SETUP;
                            end
                        end
                        default: void'(request_q.pop_front());
                    endcase
                end
            end
            drv_state     <= nxt_state;
            start         <= nxt_start;
            psel          <= nxt_psel;
            penable       <= nxt_penable;
            pwrite        <= nxt_pwrite;
            paddr         <= BLOCK_COUNT_ADDR;
            pwdata        <= nxt_pwdata;
            i_func        <= nxt_func;
            i_first_block <= nxt_first;
            i_last_block  <= nxt_last;
            i_file_id     <= nxt_fid;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with status %0d and nothing pending",
                                          o_status));
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_status, want.status));
                if (o_new_file_id !== want.new_id)
                    report_mismatch($sformatf("new_file_id got %0d expected %0d",
                                              o_new_file_id, want.new_id));
                if (o_busy_block !== want.busy_blk)
                    report_mismatch($sformatf("busy_block got %0d expected %0d",
                                              o_busy_block, want.busy_blk));
                if (o_files_recorded !== want.recorded)
                    report_mismatch($sformatf("files_recorded got %0d expected %0d",
                                              o_files_recorded, want.recorded));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        push_control(OP_SETTLE, 0);
        push_control(OP_CONFIG, 128);
        push_request(cba_pkg::F_ALLOC, 0, 0, 31, 1'b1);
        push_request(cba_pkg::F_ALLOC, 127, 127, 16, 1'b1);
        push_request(cba_pkg::F_ALLOC, 0, 127, 0, 1'b1);
        push_request(cba_pkg::F_ALLOC, 9, 3, 5, 1'b1);
        push_request(cba_pkg::F_ALLOC, 1, 126, 10, 1'b1);
        push_request(cba_pkg::F_ALLOC, 64, 64, 0, 1'b1);
        push_request(cba_pkg::F_FREE, 127, 127, 0, 1'b1);
        push_request(cba_pkg::F_FREE, 0, 0, 16, 1'b1);
        push_request(cba_pkg::F_FREE, 85, 42, 3, 1'b1);
        push_request(cba_pkg::F_FREE, 42, 85, 3, 1'b1);
        push_request(cba_pkg::F_ALLOC, 10, 20, 7, 1'b1);
        push_request(cba_pkg::F_ALLOC, 5, 15, 0, 1'b1);
        push_control(OP_SETTLE, 0);
        push_control(OP_CONFIG, 1);
        push_request(cba_pkg::F_ALLOC, 0, 0, 0, 1'b1);
        push_request(cba_pkg::F_ALLOC, 1, 1, 0, 1'b1);
        push_request(cba_pkg::F_FREE, 0, 0, 1, 1'b1);
        push_request(cba_pkg::F_ALLOC, 0, 0, 0, 1'b1);
        push_control(OP_SETTLE, 0);
        push_control(OP_CONFIG, 100);
        push_request(cba_pkg::F_ALLOC, 99, 99, 0, 1'b1);
        push_request(cba_pkg::F_ALLOC, 100, 100, 0, 1'b1);
        push_request(cba_pkg::F_ALLOC, 50, 127, 0, 1'b1);
        push_request(cba_pkg::F_FREE, 127, 0, 6, 1'b1);
        add_random_phase(128, 400, 0);
        add_random_phase($urandom_range(127, 2), 300, 0);
        add_random_phase(1, 100, 0);
        add_random_phase(128, 350, 200);
        add_random_phase($urandom_range(127, 2), 300, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (!(stim_done && expected_q.size() == 0));
        repeat (16) @(posedge i_clk);

        $display("Checked %0d results for %0d requests across %0d block_count writes",
                 results_checked, requests_sent, cfg_writes);
        $display("ok %0d, bad range %0d, busy %0d, table full %0d, id not found %0d",
                 status_seen[cba_pkg::ST_OK], status_seen[cba_pkg::ST_BAD_RANGE],
                 status_seen[cba_pkg::ST_BUSY], status_seen[cba_pkg::ST_FULL],
                 status_seen[cba_pkg::ST_NOT_FOUND]);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
